// ===== hw/rtl/pbs_pkg.sv =====
// Package for the priority bucketed stack: sizes, operation and status codes.
// No dependencies; the interfaces and the top level import it.
`default_nettype none

package pbs_pkg;

   localparam int POOL_DEPTH  = 256;
   localparam int LEVELS      = 16;
   localparam int VALUE_WIDTH = 32;

   localparam int PTR_W  = $clog2(POOL_DEPTH);
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
   localparam int FUNC_W = 2;
   localparam int STAT_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_LEVEL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

   // Link memory entry: bottom marks the oldest element of a level.
   typedef struct packed {
      logic             bottom;
      logic [PTR_W-1:0] next;
   } link_entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pbs_if.sv =====
// Channel interfaces of the priority bucketed stack: request, response, register write.
// Depends on pbs_pkg for field widths.
`default_nettype none

interface pbs_req_if import pbs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FUNC_W-1:0]      func;
   logic [VALUE_WIDTH-1:0] item_value;
   logic [LVL_W-1:0]       item_level;
   modport source (output valid, func, item_value, item_level, input ready);
   modport sink   (input valid, func, item_value, item_level, output ready);
endinterface

interface pbs_rsp_if import pbs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] top_value;
   logic [LVL_W-1:0]       top_priority;
   logic [CNT_W-1:0]       count;
   logic                   empty_flag;
   logic [STAT_W-1:0]      status;
   modport source (output valid, top_value, top_priority, count, empty_flag, status,
                   input ready);
   modport sink   (input valid, top_value, top_priority, count, empty_flag, status,
                   output ready);
endinterface

interface pbs_csr_if import pbs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LVL_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/priority_bucketed_stack.sv =====
// Priority bucketed stack top level: sequencer, pool memories and level registers.
// Depends on pbs_pkg and the channel interfaces in pbs_if.sv.
`default_nettype none

// One stack per priority level, all sharing a pool of POOL_DEPTH entries held in a
// value memory and a link memory with registered reads. After a push or a pop is
// accepted, the block steps through check and link read, list update, value read of the
// new top, and response load; a query or a rejected operation skips the list update.
// After the response load the block returns to idle, where it takes the next request;
// the response load waits while an earlier response is still held in its register.
// The registered reads of the pool memories set this order: the link read must land
// before the list update, and the new top can only be read after it. No request is
// taken while one is in progress, but a finished response may wait in its register
// while the next request runs. The free list needs no clearing pass after reset: a
// high-water mark stands for the never-used entries. The register write channel is
// always ready.
module priority_bucketed_stack
   import pbs_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   pbs_req_if.sink    req,
   pbs_rsp_if.source  rsp,
   pbs_csr_if.sink    csr
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_TOP_RD,
      ST_TOP_OUT
   } state_type;

   state_type state_ff, state_in;

   // Request and working registers.
   logic [FUNC_W-1:0]      func_ff, func_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;
   logic [LVL_W-1:0]       sel_ff, sel_in;
   logic [STAT_W-1:0]      stat_ff, stat_in;
   logic                   do_op_ff, do_op_in;

   // Stack state.
   logic [LVL_W-1:0]       top_level_ff, top_level_in;
   logic [PTR_W-1:0]       head_ff [LEVELS];
   logic [PTR_W-1:0]       head_in [LEVELS];
   logic [LEVELS-1:0]      nonempty_ff, nonempty_in;
   logic [PTR_W-1:0]       free_head_ff, free_head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       hwm_ff, hwm_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [LVL_W-1:0]       rsp_prio_ff, rsp_prio_in;
   logic [CNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic [STAT_W-1:0]      rsp_stat_ff, rsp_stat_in;

   // Pool memories.
   logic [VALUE_WIDTH-1:0] value_mem_ff [POOL_DEPTH];
   link_entry_type         link_mem_ff  [POOL_DEPTH];
   logic [VALUE_WIDTH-1:0] value_rd_ff;
   link_entry_type         link_rd_ff;

   logic                   value_we, value_re;
   logic [PTR_W-1:0]       value_wa, value_ra;
   logic                   link_we, link_re;
   logic [PTR_W-1:0]       link_wa, link_ra;
   link_entry_type         link_wd;

   // Highest nonempty level.
   logic                   hi_valid;
   logic [LVL_W-1:0]       hi_level;

   logic                   node_fresh;
   logic                   rsp_free;

   always_comb begin
      hi_valid = 1'b0;
      hi_level = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (nonempty_ff[i]) begin
            hi_valid = 1'b1;
            hi_level = LVL_W'(i);
         end
      end
   end

   // The free head is a never-used entry exactly when the high-water mark is below POOL_DEPTH and the head equals it.
   assign node_fresh = (hwm_ff < CNT_W'(POOL_DEPTH)) && (free_head_ff == hwm_ff[PTR_W-1:0]);
   assign rsp_free   = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      val_in        = val_ff;
      lvl_in        = lvl_ff;
      sel_in        = sel_ff;
      stat_in       = stat_ff;
      do_op_in      = do_op_ff;
      top_level_in  = top_level_ff;
      head_in       = head_ff;
      nonempty_in   = nonempty_ff;
      free_head_in  = free_head_ff;
      count_in      = count_ff;
      hwm_in        = hwm_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_stat_in   = rsp_stat_ff;
      value_we      = 1'b0;
      value_wa      = free_head_ff;
      value_re      = 1'b0;
      value_ra      = head_ff[hi_level];
      link_we       = 1'b0;
      link_wa       = free_head_ff;
      link_wd       = '0;
      link_re       = 1'b0;
      link_ra       = free_head_ff;

      if (csr.valid) begin
         top_level_in = csr.data;
      end
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               func_in  = req.func;
               val_in   = req.item_value;
               lvl_in   = req.item_level;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            stat_in  = STAT_OK;
            do_op_in = 1'b0;
            state_in = ST_TOP_RD;
            case (func_ff)
               FUNC_PUSH: begin
                  sel_in = lvl_ff;
                  if (lvl_ff > top_level_ff) begin
                     stat_in = STAT_BAD_LEVEL;
                  end else if (count_ff >= CNT_W'(POOL_DEPTH)) begin
                     stat_in = STAT_FULL;
                  end else begin
                     do_op_in = 1'b1;
                     link_re  = 1'b1;
                     link_ra  = free_head_ff;
                     state_in = ST_UPDATE;
                  end
               end
               FUNC_POP: begin
                  sel_in = hi_level;
                  if (!hi_valid) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     do_op_in = 1'b1;
                     link_re  = 1'b1;
                     link_ra  = head_ff[hi_level];
                     state_in = ST_UPDATE;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_UPDATE: begin
            state_in = ST_TOP_RD;
            if (func_ff == FUNC_PUSH) begin
               value_we = 1'b1;
               value_wa = free_head_ff;
               link_we  = 1'b1;
               link_wa  = free_head_ff;
               if (nonempty_ff[sel_ff]) begin
                  link_wd = '{bottom: 1'b0, next: head_ff[sel_ff]};
               end else begin
                  link_wd = '{bottom: 1'b1, next: free_head_ff};
               end
               if (node_fresh) begin
                  free_head_in = free_head_ff + PTR_W'(1);
                  hwm_in       = hwm_ff + CNT_W'(1);
               end else begin
                  free_head_in = link_rd_ff.next;
               end
               head_in[sel_ff]     = free_head_ff;
               nonempty_in[sel_ff] = 1'b1;
               count_in            = count_ff + CNT_W'(1);
            end else begin
               // Pop: the head node goes back to the front of the free list.
               if (link_rd_ff.bottom) begin
                  nonempty_in[sel_ff] = 1'b0;
               end else begin
                  head_in[sel_ff] = link_rd_ff.next;
               end
               link_we      = 1'b1;
               link_wa      = head_ff[sel_ff];
               link_wd      = '{bottom: 1'b0, next: free_head_ff};
               free_head_in = head_ff[sel_ff];
               count_in     = count_ff - CNT_W'(1);
            end
         end
         ST_TOP_RD: begin
            value_re = 1'b1;
            value_ra = head_ff[hi_level];
            state_in = ST_TOP_OUT;
         end
         ST_TOP_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = hi_valid ? value_rd_ff : '0;
               rsp_prio_in  = hi_valid ? hi_level : '0;
               rsp_count_in = count_ff;
               rsp_stat_in  = stat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_level_ff <= LVL_W'(LEVELS - 1);
         nonempty_ff  <= '0;
         free_head_ff <= '0;
         count_ff     <= '0;
         hwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_level_ff <= top_level_in;
         nonempty_ff  <= nonempty_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         hwm_ff       <= hwm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff      <= func_in;
      val_ff       <= val_in;
      lvl_ff       <= lvl_in;
      sel_ff       <= sel_in;
      stat_ff      <= stat_in;
      do_op_ff     <= do_op_in;
      head_ff      <= head_in;
      rsp_value_ff <= rsp_value_in;
      rsp_prio_ff  <= rsp_prio_in;
      rsp_count_ff <= rsp_count_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   always_ff @(posedge clock) begin
      if (value_we && do_op_ff) begin
         value_mem_ff[value_wa] <= val_ff;
      end
      if (value_re) begin
         value_rd_ff <= value_mem_ff[value_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we && do_op_ff) begin
         link_mem_ff[link_wa] <= link_wd;
      end
      if (link_re) begin
         link_rd_ff <= link_mem_ff[link_ra];
      end
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign csr.ready        = 1'b1;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.top_value    = rsp_value_ff;
   assign rsp.top_priority = rsp_prio_ff;
   assign rsp.count        = rsp_count_ff;
   assign rsp.empty_flag   = (rsp_count_ff == '0);
   assign rsp.status       = rsp_stat_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pbs_checker.sv =====
// Port-level checks for the priority bucketed stack, bound to the top level.
// Depends on pbs_pkg and on the top level priority_bucketed_stack.
`default_nettype none

module pbs_checker
   import pbs_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_ready,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire [VALUE_WIDTH-1:0] rsp_top_value,
   input wire [LVL_W-1:0]       rsp_top_priority,
   input wire [CNT_W-1:0]       rsp_count,
   input wire                   rsp_empty_flag,
   input wire [STAT_W-1:0]      rsp_status
);

   // A stalled response stays valid and keeps its value, count and status.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_value) && $stable(rsp_count)
                                  && $stable(rsp_status))
      else $error("response changed while stalled");

   // The block works on one transaction at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_flag |-> rsp_top_value == '0 && rsp_top_priority == '0)
      else $error("empty stack reports a top element");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_EMPTY |-> rsp_empty_flag)
      else $error("pop reported empty on a nonempty stack");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |-> rsp_count == CNT_W'(POOL_DEPTH))
      else $error("pool full reported below capacity");

endmodule

bind priority_bucketed_stack pbs_checker u_pbs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_top_value    (rsp.top_value),
   .rsp_top_priority (rsp.top_priority),
   .rsp_count        (rsp.count),
   .rsp_empty_flag   (rsp.empty_flag),
   .rsp_status       (rsp.status)
);

`default_nettype wire
